// ===== rtl/scfla_pkg.sv =====
// ============================================================================
// scfla_pkg
// Shared types and constants of the size-class free-list allocator.
// ============================================================================
`default_nettype none

package scfla_pkg;

    // number of base address registers on the configuration port
    localparam int REG_COUNT = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] BASE_RESET [REG_COUNT] = '{
        32'd0, 32'd65536, 32'd196608, 32'd458752, 32'd983040
    };

    // action codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_FOREIGN   = 3'd4,
        ST_NULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] release_address;
    } req_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] slot_address;
        logic [2:0]  size_class;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic start;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic needs_read;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/scfla_dp.sv =====
// ============================================================================
// scfla_dp
// Allocator datapath: base registers, list heads, link memory, class decode
// and the result register.
// ============================================================================
`default_nettype none

module scfla_dp
    import scfla_pkg::*;
#(
    parameter int SLOTS_PER_CLASS = 1024,
    parameter int NUM_CLASSES     = 5,
    parameter int MIN_SLOT_LOG2   = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                sts,
    input  wire req_item_t            req,
    output rsp_item_t                 rsp,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int IW        = $clog2(SLOTS_PER_CLASS);
    localparam int LINK_W    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SPAN_W    = IW + MIN_SLOT_LOG2 + NUM_CLASSES;
    localparam int HI_W      = ((SPAN_W > 32) ? SPAN_W : 32) + 1;

    logic [31:0]        base_reg [REG_COUNT];
    logic [LINK_W-1:0]  head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]  link_mem [MEM_DEPTH];
    logic [LINK_W-1:0]  rd_data_reg;
    logic [CLS_W-1:0]   pend_cls_reg;
    logic [CLS_W-1:0]   clr_cls_reg;
    logic [IW-1:0]      clr_idx_reg;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;

    // decode results
    logic               a_found;
    logic [CLS_W-1:0]   a_sel;
    logic [LINK_W-1:0]  a_head;
    logic [31:0]        a_addr;
    logic               a_exhausted;
    logic               r_null;
    logic               r_found;
    logic [CLS_W-1:0]   r_sel;
    logic [IW-1:0]      r_idx;
    logic [LINK_W-1:0]  r_head;
    logic               do_release;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa;
    logic [LINK_W-1:0]  mem_wd;

    function automatic logic [MEM_AW-1:0] flat_addr(input logic [CLS_W-1:0] cls,
                                                    input logic [IW-1:0] idx);
        logic [MEM_AW:0] row;
        row = (MEM_AW + 1)'(cls) * (MEM_AW + 1)'(SLOTS_PER_CLASS);
        return row[MEM_AW-1:0] + MEM_AW'(idx);
    endfunction

    // class search, first match wins
    always_comb
    begin
        logic [HI_W-1:0] lo;
        logic [HI_W-1:0] hi;
        logic [HI_W-1:0] addr_x;
        a_found = 1'b0;
        a_sel   = '0;
        a_head  = '0;
        a_addr  = '0;
        r_found = 1'b0;
        r_sel   = '0;
        r_idx   = '0;
        r_head  = '0;
        addr_x  = HI_W'(req.release_address);
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (!a_found && ((req.request_size >> (MIN_SLOT_LOG2 + c)) == 32'd0))
            begin
                a_found = 1'b1;
                a_sel   = CLS_W'(c);
                a_head  = head_reg[c];
                a_addr  = base_reg[c]
                        + (32'(head_reg[c][IW-1:0]) << (MIN_SLOT_LOG2 + c));
            end
            lo = HI_W'(base_reg[c]);
            hi = lo + (HI_W'(SLOTS_PER_CLASS) << (MIN_SLOT_LOG2 + c));
            if (!r_found && (addr_x >= lo) && (addr_x < hi))
            begin
                r_found = 1'b1;
                r_sel   = CLS_W'(c);
                r_head  = head_reg[c];
                r_idx   = IW'((req.release_address - base_reg[c])
                              >> (MIN_SLOT_LOG2 + c));
            end
        end
    end

    assign a_exhausted = (a_head >= LINK_W'(SLOTS_PER_CLASS));
    assign r_null      = (req.release_address == 32'd0);
    assign do_release  = (req.action == ACT_RELEASE) && !r_null && r_found;

    always_comb
    begin
        rsp_next.status       = ST_TOO_LARGE;
        rsp_next.slot_address = 32'd0;
        rsp_next.size_class   = 3'd0;
        if (req.action == ACT_ALLOC)
        begin
            if (a_found && a_exhausted)
            begin
                rsp_next.status     = ST_EXHAUSTED;
                rsp_next.size_class = 3'(a_sel);
            end
            else if (a_found)
            begin
                rsp_next.status       = ST_ALLOCATED;
                rsp_next.slot_address = a_addr;
                rsp_next.size_class   = 3'(a_sel);
            end
        end
        else if (r_null)
        begin
            rsp_next.status = ST_NULL;
        end
        else if (r_found)
        begin
            rsp_next.status     = ST_RELEASED;
            rsp_next.size_class = 3'(r_sel);
        end
        else
        begin
            rsp_next.status = ST_FOREIGN;
        end
    end

    assign sts.needs_read = (req.action == ACT_ALLOC) && a_found && !a_exhausted;
    assign sts.clear_last = (clr_cls_reg == CLS_W'(NUM_CLASSES - 1))
                         && (clr_idx_reg == IW'(SLOTS_PER_CLASS - 1));

    // single write port: init sweep or release push
    always_comb
    begin
        if (cmd.clear_en)
        begin
            mem_we = 1'b1;
            mem_wa = flat_addr(clr_cls_reg, clr_idx_reg);
            mem_wd = LINK_W'(clr_idx_reg) + LINK_W'(1);
        end
        else
        begin
            mem_we = cmd.start && do_release;
            mem_wa = flat_addr(r_sel, r_idx);
            mem_wd = r_head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (cmd.start && sts.needs_read)
        begin
            rd_data_reg <= link_mem[flat_addr(a_sel, a_head[IW-1:0])];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                base_reg[i] <= BASE_RESET[i];
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
            end
            clr_cls_reg <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT)))
            begin
                base_reg[cfg_index] <= cfg_data;
            end
            if (cmd.clear_en && !sts.clear_last)
            begin
                if (clr_idx_reg == IW'(SLOTS_PER_CLASS - 1))
                begin
                    clr_idx_reg <= '0;
                    clr_cls_reg <= clr_cls_reg + CLS_W'(1);
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + IW'(1);
                end
            end
            if (cmd.start && do_release)
            begin
                head_reg[r_sel] <= LINK_W'(r_idx);
            end
            if (cmd.finish)
            begin
                head_reg[pend_cls_reg] <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rsp_reg      <= rsp_next;
            pend_cls_reg <= a_sel;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/scfla_ctrl.sv =====
// ============================================================================
// scfla_ctrl
// Allocator controller: init sweep, request acceptance, link read wait and
// result valid.
// ============================================================================
`default_nettype none

module scfla_ctrl
    import scfla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // result register is free when empty or handed off this cycle
    assign req_stall = !((state_reg == S_IDLE) && !(out_valid_reg && rsp_stall));
    assign accept    = req_valid && !req_stall;

    assign cmd.clear_en = (state_reg == S_CLEAR);
    assign cmd.start    = accept;
    assign cmd.finish   = (state_reg == S_READ);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && sts.needs_read)
                begin
                    state_next = S_READ;
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    // no request taken during the init sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !accept)
        else $error("request accepted during link init");

    // a pop always completes in the following cycle
    a_read_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.needs_read) |=> cmd.finish)
        else $error("link read not followed by head update");

    // result register must be free while the pop completes
    a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg)
        else $error("result register busy during pop");

    // a beat is presented the cycle after a pop completes
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid)
        else $error("pop result not presented");

endmodule

`default_nettype wire

// ===== rtl/size_class_free_list_allocator_top.sv =====
// ============================================================================
// size_class_free_list_allocator_top
// Segregated free-list slot allocator with power-of-two size classes.
// ============================================================================
// After reset the block runs an init sweep that writes the free chain of every
// class into the link memory, one entry per cycle, NUM_CLASSES * SLOTS_PER_CLASS
// entries in all (5120 at the defaults); requests stall until it ends,
// while base register writes are taken at once. Then each request beat gives
// one result beat. Release, null, foreign, too-large and exhausted requests
// are registered into the result register on acceptance; an allocation that
// pops a slot also passes through a read state, in which the registered read
// of the popped entry's link in the single link memory updates the class head.
`default_nettype none

module size_class_free_list_allocator_top
    import scfla_pkg::*;
#(
    parameter int SLOTS_PER_CLASS = 1024,
    parameter int NUM_CLASSES     = 5,
    parameter int MIN_SLOT_LOG2   = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_item_t            req,
    // result channel
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_item_t                 rsp,
    // base register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // base registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    scfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    scfla_dp #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_SLOT_LOG2   (MIN_SLOT_LOG2)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== tb/size_class_free_list_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_checker
// Watches the request, result and base register channels of the allocator.
// Keeps a private copy of the per-class free lists and bases, works out the
// outcome of every accepted request beat and compares each result beat
// field by field with the oldest outcome still owed.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_checker
    import scfla_pkg::*;
#(
    parameter int SLOTS_PER_CLASS = 1024,
    parameter int NUM_CLASSES     = 5,
    parameter int MIN_SLOT_LOG2   = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  req_item_t            req,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  rsp_item_t            rsp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_W = $clog2(SLOTS_PER_CLASS + 1);
    localparam int MAX_PRINTS = 40;

    logic [LINK_W-1:0] free_link [NUM_CLASSES][SLOTS_PER_CLASS];
    logic [LINK_W-1:0] free_head [NUM_CLASSES];
    logic [31:0]       base_reg  [REG_COUNT];
    rsp_item_t         results_owed [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // pops or pushes a slot on the private free lists and returns the outcome
    function automatic rsp_item_t serve_request(input req_item_t r);
        rsp_item_t         o;
        int                sh;
        logic [LINK_W-1:0] idx;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [63:0]       offs;
        logic              done;
        o    = '{status: ST_TOO_LARGE, slot_address: '0, size_class: '0};
        done = 1'b0;
        if (r.action == ACT_ALLOC) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                sh = MIN_SLOT_LOG2 + c;
                if (!done && {32'd0, r.request_size} < (64'd1 << sh)) begin
                    done         = 1'b1;
                    idx          = free_head[c];
                    o.size_class = 3'(c);
                    if (idx >= SLOTS_PER_CLASS) begin
                        o.status = ST_EXHAUSTED;
                    end else begin
                        free_head[c]   = free_link[c][idx];
                        o.status       = ST_ALLOCATED;
                        o.slot_address = base_reg[c] + (32'(idx) << sh);
                    end
                end
            end
        end else if (r.release_address == '0) begin
            o.status = ST_NULL;
        end else begin
            o.status = ST_FOREIGN;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                sh = MIN_SLOT_LOG2 + c;
                lo = {32'd0, base_reg[c]};
                hi = lo + (64'(SLOTS_PER_CLASS) << sh);
                if (!done && {32'd0, r.release_address} >= lo
                        && {32'd0, r.release_address} < hi) begin
                    done = 1'b1;
                    offs = ({32'd0, r.release_address} - lo) >> sh;
                    if (offs >= SLOTS_PER_CLASS)
                        offs = 64'(SLOTS_PER_CLASS - 1);
                    idx               = offs[LINK_W-1:0];
                    free_link[c][idx] = free_head[c];
                    free_head[c]      = idx;
                    o.status          = ST_RELEASED;
                    o.size_class      = 3'(c);
                end
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_item_t want;
        if (!rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                for (int j = 0; j < SLOTS_PER_CLASS; j++)
                    free_link[c][j] = LINK_W'(j + 1);
                free_head[c] = '0;
            end
            for (int i = 0; i < REG_COUNT; i++)
                base_reg[i] = BASE_RESET[i];
            results_owed.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < REG_COUNT)
                base_reg[cfg_index] = cfg_data;
            // a result never belongs to a request taken at the same edge
            if (rsp_valid && !rsp_stall) begin
                if (results_owed.size() == 0) begin
                    report_mismatch("result beat with nothing owed", rsp.slot_address, '0);
                end else begin
                    want = results_owed.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.slot_address !== want.slot_address)
                        report_mismatch("slot_address", rsp.slot_address, want.slot_address);
                    if (rsp.size_class !== want.size_class)
                        report_mismatch("size_class", 32'(rsp.size_class), 32'(want.size_class));
                end
            end
            if (req_valid && !req_stall)
                results_owed.push_back(serve_request(req));
            pending <= results_owed.size();
        end
    end

endmodule

// ===== tb/size_class_free_list_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top_tb
// Drives allocate and release beats into the size-class allocator under
// random gaps and result back-pressure, across several base settings, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_top_tb;
    import scfla_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS_PER_CLASS = 1024;
    localparam int NUM_CLASSES     = 5;
    localparam int MIN_SLOT_LOG2   = 6;

    // the init sweep alone writes NUM_CLASSES * SLOTS_PER_CLASS link entries
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    // class drained to exhaustion in the first phase
    localparam int DRAIN_CLASS = 3;
    // an index past the last base register, written and ignored
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_item_t            req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_item_t            rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int mismatches;
    int pending;

    // stimulus side bookkeeping
    logic [31:0] cur_base  [REG_COUNT];
    logic [31:0] next_base [REG_COUNT];
    logic [31:0] live_slots [$];      // addresses handed out and not yet given back
    int          status_seen [8];
    int          beats_sent;
    int          base_writes;
    int          cycle_count;
    logic        no_gaps;
    logic        hold_rsp;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    size_class_free_list_allocator_top #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_SLOT_LOG2   (MIN_SLOT_LOG2)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    size_class_free_list_allocator_checker #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_SLOT_LOG2   (MIN_SLOT_LOG2)
    ) allocator_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // harvest handed-out addresses so later releases give back real slots
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            status_seen[rsp.status]++;
            if (rsp.status == ST_ALLOCATED)
                live_slots.push_back(rsp.slot_address);
        end
    end

    // sender gap: mostly none, sometimes a few cycles, rarely a long pause
    function automatic int gap_cycles();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // length of one stall or one open run on the result side
    function automatic int run_length();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(2, 1);
        if (r < 85)
            return $urandom_range(8, 3);
        if (r < 97)
            return $urandom_range(30, 9);
        return $urandom_range(80, 40);
    endfunction

    function automatic req_item_t make_alloc(input logic [31:0] size);
        req_item_t it;
        it.action          = ACT_ALLOC;
        it.request_size    = size;
        it.release_address = $urandom;
        return it;
    endfunction

    function automatic req_item_t make_release(input logic [31:0] addr);
        req_item_t it;
        it.action          = ACT_RELEASE;
        it.request_size    = $urandom;
        it.release_address = addr;
        return it;
    endfunction

    // mostly well-formed traffic: fitting sizes and addresses that were handed out,
    // with some oversize, foreign, null and region-edge beats mixed in
    function automatic req_item_t random_item();
        req_item_t   it;
        int          r;
        int          c;
        int          sh;
        int          pick;
        int          k;
        logic [31:0] span;
        it   = make_alloc($urandom);
        r    = $urandom_range(99);
        c    = $urandom_range(NUM_CLASSES - 1);
        sh   = MIN_SLOT_LOG2 + c;
        span = 32'(SLOTS_PER_CLASS) << sh;
        pick = $urandom_range(19);
        if (r < 50)
        begin
            if (pick < 16)
                it.request_size = $urandom_range((1 << sh) - 1, (c == 0) ? 0 : (1 << (sh - 1)));
            else if (pick < 18)
                it.request_size = $urandom_range(32'hFFFF_FFFF,
                                                 1 << (MIN_SLOT_LOG2 + NUM_CLASSES - 1));
            else if (pick == 18)
                it.request_size = 32'd1 << (MIN_SLOT_LOG2 + NUM_CLASSES - 1);
            // else keep the fully random size
        end
        else
        begin
            it.action = ACT_RELEASE;
            if (r < 80 && live_slots.size() > 0)
            begin
                k = $urandom_range(live_slots.size() - 1);
                it.release_address = live_slots[k];
                live_slots.delete(k);
            end
            else if (r < 88)
                it.release_address = cur_base[c] + $urandom_range(span - 1);
            else if (r < 94)
                it.release_address = $urandom;
            else if (r < 97)
                it.release_address = '0;
            else if (pick < 7)
                it.release_address = cur_base[c] - 32'd1;
            else if (pick < 14)
                it.release_address = cur_base[c] + span;
            else
                it.release_address = cur_base[c];
        end
        return it;
    endfunction

    // offer one request beat and hold it until taken; valid stays up afterwards
    task automatic send_beat(input req_item_t it);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        beats_sent++;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int hold_at);
        for (int n = 0; n < count; n++)
        begin
            // every so often switch to a back-to-back stretch
            if (n % 64 == 0)
                no_gaps = ($urandom_range(3) == 0);
            if (n == hold_at)
                hold_rsp = 1'b1;
            send_beat(random_item());
        end
        no_gaps = 1'b0;
        req_valid <= 1'b0;
    endtask

    // every owed result back, then a settling wait
    task automatic wait_idle();
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write next_base into every base register, optionally poking an unmapped index
    task automatic program_bases(input logic with_unmapped);
        for (int i = 0; i <= REG_COUNT; i++)
        begin
            if (i < REG_COUNT || with_unmapped)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= (i < REG_COUNT) ? CFG_IDX_W'(i) : UNMAPPED_REG;
                cfg_data  <= (i < REG_COUNT) ? next_base[i] : $urandom;
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                if (i < REG_COUNT)
                    cur_base[i] = next_base[i];
                base_writes++;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, quiet stretches, and the long hold when asked
    initial
    begin
        int len;
        rsp_stall = 1'b0;
        forever
        begin
            if (hold_rsp)
            begin
                // long hold so the block backs up and stalls its input
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if ($urandom_range(4) == 0)
            begin
                rsp_stall <= 1'b0;
                len = $urandom_range(150, 50);
                repeat (len) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                len = run_length();
                repeat (len) @(posedge clk);
                rsp_stall <= 1'b1;
                len = run_length();
                repeat (len) @(posedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results owed", cycle_count, pending);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] slot_bytes;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        hold_rsp    = 1'b0;
        beats_sent  = 0;
        base_writes = 0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < REG_COUNT; i++)
            cur_base[i] = BASE_RESET[i];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // phase 0: reset bases written back explicitly, taken during the init sweep
        for (int i = 0; i < REG_COUNT; i++)
            next_base[i] = BASE_RESET[i];
        program_bases(1'b0);

        // directed beats: class edges, oversize, null, foreign, misaligned, double release
        send_beat(make_alloc(32'd0));                  // class 0 slot 0, address zero
        send_beat(make_alloc(32'd63));
        send_beat(make_alloc(32'd64));                 // first size of class 1
        send_beat(make_alloc(32'd127));
        send_beat(make_alloc(32'd128));
        send_beat(make_alloc(32'd255));
        send_beat(make_alloc(32'd256));
        send_beat(make_alloc(32'd511));
        send_beat(make_alloc(32'd512));
        send_beat(make_alloc(32'd1023));
        send_beat(make_alloc(32'd1024));               // just past the largest class
        send_beat(make_alloc(32'hFFFF_FFFF));
        send_beat(make_release(32'd0));                // null even though class 0 covers it
        send_beat(make_release(cur_base[0] + 32'd64));
        send_beat(make_release(cur_base[1] + 32'd128 + 32'd5));   // misaligned, truncates
        send_beat(make_release(cur_base[1] + 32'd128));           // same slot again
        send_beat(make_alloc(32'd100));
        send_beat(make_alloc(32'd100));                // list now loops on that slot
        send_beat(make_release(32'hFFFF_FFFF));
        send_beat(make_release(cur_base[4] + (32'(SLOTS_PER_CLASS) << 10)));  // one past end
        send_beat(make_release(cur_base[4] + (32'(SLOTS_PER_CLASS) << 10) - 32'd1));
        send_beat(make_release(cur_base[0] + (32'(SLOTS_PER_CLASS) << 6) - 32'd1));
        send_beat(make_release(cur_base[4] + 32'd1024 + 32'd1));
        send_beat(make_alloc(32'd512));

        // drain one class until it reports exhaustion, then give one slot back;
        // the long result hold lands inside this stretch while beats keep coming
        hold_rsp = 1'b1;
        slot_bytes = 32'd1 << (MIN_SLOT_LOG2 + DRAIN_CLASS);
        for (int n = 0; n < SLOTS_PER_CLASS + 6; n++)
            send_beat(make_alloc($urandom_range(slot_bytes - 1, slot_bytes / 2)));
        send_beat(make_release(cur_base[DRAIN_CLASS] + 7 * slot_bytes));
        send_beat(make_alloc(slot_bytes / 2));
        send_beat(make_alloc(slot_bytes - 1));         // empty again
        req_valid <= 1'b0;

        run_random(40, 10);

        // phase 1: extremes, top of the address space, wrap, overlap, unaligned base
        wait_idle();
        live_slots.delete();
        next_base[0] = 32'hFFFF_0000;
        next_base[1] = 32'h0000_0000;
        next_base[2] = 32'h0000_8000;
        next_base[3] = 32'hFFFF_FFFF;
        next_base[4] = 32'hFFFF_FC00;
        program_bases(1'b1);
        run_random(30, -1);

        // phase 2: random bases, mostly slot-aligned
        wait_idle();
        live_slots.delete();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            next_base[i] = $urandom & ~((32'd1 << (MIN_SLOT_LOG2 + i)) - 32'd1);
            if ($urandom_range(3) == 0)
                next_base[i] = $urandom;
        end
        program_bases(1'b0);
        run_random(40, 15);

        wait_idle();
        $display("covered %0d request beats and %0d base writes over three base settings",
                 beats_sent, base_writes);
        $display("results: alloc %0d exhausted %0d too-large %0d released %0d foreign %0d null %0d",
                 status_seen[ST_ALLOCATED], status_seen[ST_EXHAUSTED], status_seen[ST_TOO_LARGE],
                 status_seen[ST_RELEASED], status_seen[ST_FOREIGN], status_seen[ST_NULL]);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scfla_pkg.sv
rtl/scfla_dp.sv
rtl/scfla_ctrl.sv
rtl/size_class_free_list_allocator_top.sv
tb/size_class_free_list_allocator_checker.sv
tb/size_class_free_list_allocator_top_tb.sv
